// File: rtl/tone_stack_state_space_filter_top_assert.svh
// Assertion macros shared by the tone stack filter RTL.
`ifndef TONE_STACK_STATE_SPACE_FILTER_TOP_ASSERT_SVH
`define TONE_STACK_STATE_SPACE_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define TSSF_CHECK_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tone stack filter check failed");

// next-cycle implication
`define TSSF_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tone stack filter check failed");

`endif

// File: rtl/tssf_pkg.sv
`default_nettype none

package tssf_pkg;

   localparam int STATE_W    = 32;
   localparam int FRAC_BITS  = 12;
   localparam int NUM_REGS   = 5;
   localparam int REG_W      = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int PC_W       = 5;
   localparam int ROW_W      = 3;

   localparam logic [ROW_W-1:0] ROW_TREBLE = 3'd0;
   localparam logic [ROW_W-1:0] ROW_BASS   = 3'd1;
   localparam logic [ROW_W-1:0] ROW_MID    = 3'd2;
   localparam logic [ROW_W-1:0] ROW_OUT    = 3'd3;
   localparam logic [ROW_W-1:0] ROW_COMP   = 3'd4;

   localparam logic [1:0] LANE_SAMPLE = 2'd0;
   localparam logic [1:0] LANE_SRC0   = 2'd1;
   localparam logic [1:0] LANE_SRC1   = 2'd2;
   localparam logic [1:0] LANE_SRC2   = 2'd3;
   localparam logic [1:0] LANE_GEQ0   = 2'd0;
   localparam logic [1:0] LANE_GEQ1   = 2'd1;
   localparam logic [1:0] LANE_GEQ2   = 2'd2;
   localparam logic [1:0] LANE_THETA  = 2'd3;

   localparam logic [1:0] IDX0 = 2'd0;
   localparam logic [1:0] IDX1 = 2'd1;
   localparam logic [1:0] IDX2 = 2'd2;

   typedef enum logic [1:0] {
      ACC_NOP   = 2'd0,
      ACC_FIRST = 2'd1,
      ACC_ADD   = 2'd2
   } acc_op_type;

   typedef enum logic {
      PRE_MUL   = 1'b0,
      PRE_SHIFT = 1'b1
   } pre_op_type;

   typedef enum logic [1:0] {
      OPND_X = 2'd0,
      OPND_V = 2'd1,
      OPND_I = 2'd2,
      OPND_S = 2'd3
   } opnd_type;

   typedef enum logic [2:0] {
      DST_NONE = 3'd0,
      DST_S    = 3'd1,
      DST_V    = 3'd2,
      DST_I    = 3'd3,
      DST_Y    = 3'd4
   } dest_type;

   typedef enum logic {
      JMP_NEXT = 1'b0,
      JMP_END  = 1'b1
   } jmp_type;

   typedef struct packed {
      acc_op_type       acc_op;
      pre_op_type       pre_op;
      logic [ROW_W-1:0] coef_row;
      logic [1:0]       coef_lane;
      opnd_type         opnd;
      logic [1:0]       opnd_idx;
      dest_type         dest;
      logic [1:0]       dest_idx;
      jmp_type          jmp;
   } ctl_type;

   typedef struct packed {
      logic            busy;
      logic            emit;
      logic [PC_W-1:0] pc;
   } seq_status_type;

   function automatic ctl_type cw(
      input acc_op_type       acc_op,
      input pre_op_type       pre_op,
      input logic [ROW_W-1:0] coef_row,
      input logic [1:0]       coef_lane,
      input opnd_type         opnd,
      input logic [1:0]       opnd_idx,
      input dest_type         dest,
      input logic [1:0]       dest_idx,
      input jmp_type          jmp
   );
      ctl_type w;
      w.acc_op    = acc_op;
      w.pre_op    = pre_op;
      w.coef_row  = coef_row;
      w.coef_lane = coef_lane;
      w.opnd      = opnd;
      w.opnd_idx  = opnd_idx;
      w.dest      = dest;
      w.dest_idx  = dest_idx;
      w.jmp       = jmp;
      return w;
   endfunction

   function automatic ctl_type nop_word();
      return cw(ACC_NOP, PRE_MUL, ROW_COMP, LANE_GEQ0, OPND_X, IDX0, DST_NONE, IDX0,
                JMP_NEXT);
   endfunction

   // Microprogram: sources, four matrix rows, then currents.
   function automatic ctl_type rom_word(input logic [PC_W-1:0] pc);
      ctl_type w;
      w = nop_word();
      case (pc)
         5'd0:  w = cw(ACC_FIRST, PRE_MUL, ROW_COMP, LANE_GEQ0, OPND_V, IDX0,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd1:  w = cw(ACC_ADD, PRE_MUL, ROW_COMP, LANE_THETA, OPND_I, IDX0,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd2:  w = cw(ACC_FIRST, PRE_MUL, ROW_COMP, LANE_GEQ1, OPND_V, IDX1,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd3:  w = cw(ACC_ADD, PRE_MUL, ROW_COMP, LANE_THETA, OPND_I, IDX1,
                      DST_S, IDX0, JMP_NEXT);
         5'd4:  w = cw(ACC_FIRST, PRE_MUL, ROW_COMP, LANE_GEQ2, OPND_V, IDX2,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd5:  w = cw(ACC_ADD, PRE_MUL, ROW_COMP, LANE_THETA, OPND_I, IDX2,
                      DST_S, IDX1, JMP_NEXT);
         5'd6:  w = cw(ACC_FIRST, PRE_MUL, ROW_TREBLE, LANE_SAMPLE, OPND_X, IDX0,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd7:  w = cw(ACC_ADD, PRE_MUL, ROW_TREBLE, LANE_SRC0, OPND_S, IDX0,
                      DST_S, IDX2, JMP_NEXT);
         5'd8:  w = cw(ACC_ADD, PRE_MUL, ROW_TREBLE, LANE_SRC1, OPND_S, IDX1,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd9:  w = cw(ACC_ADD, PRE_MUL, ROW_TREBLE, LANE_SRC2, OPND_S, IDX2,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd10: w = cw(ACC_FIRST, PRE_MUL, ROW_BASS, LANE_SAMPLE, OPND_X, IDX0,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd11: w = cw(ACC_ADD, PRE_MUL, ROW_BASS, LANE_SRC0, OPND_S, IDX0,
                      DST_V, IDX0, JMP_NEXT);
         5'd12: w = cw(ACC_ADD, PRE_MUL, ROW_BASS, LANE_SRC1, OPND_S, IDX1,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd13: w = cw(ACC_ADD, PRE_MUL, ROW_BASS, LANE_SRC2, OPND_S, IDX2,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd14: w = cw(ACC_FIRST, PRE_MUL, ROW_MID, LANE_SAMPLE, OPND_X, IDX0,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd15: w = cw(ACC_ADD, PRE_MUL, ROW_MID, LANE_SRC0, OPND_S, IDX0,
                      DST_V, IDX1, JMP_NEXT);
         5'd16: w = cw(ACC_ADD, PRE_MUL, ROW_MID, LANE_SRC1, OPND_S, IDX1,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd17: w = cw(ACC_ADD, PRE_MUL, ROW_MID, LANE_SRC2, OPND_S, IDX2,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd18: w = cw(ACC_FIRST, PRE_MUL, ROW_OUT, LANE_SAMPLE, OPND_X, IDX0,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd19: w = cw(ACC_ADD, PRE_MUL, ROW_OUT, LANE_SRC0, OPND_S, IDX0,
                      DST_V, IDX2, JMP_NEXT);
         5'd20: w = cw(ACC_ADD, PRE_MUL, ROW_OUT, LANE_SRC1, OPND_S, IDX1,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd21: w = cw(ACC_ADD, PRE_MUL, ROW_OUT, LANE_SRC2, OPND_S, IDX2,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd22: w = cw(ACC_FIRST, PRE_SHIFT, ROW_COMP, LANE_GEQ0, OPND_S, IDX0,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd23: w = cw(ACC_ADD, PRE_MUL, ROW_COMP, LANE_GEQ0, OPND_V, IDX0,
                      DST_Y, IDX0, JMP_NEXT);
         5'd24: w = cw(ACC_FIRST, PRE_SHIFT, ROW_COMP, LANE_GEQ1, OPND_S, IDX1,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd25: w = cw(ACC_ADD, PRE_MUL, ROW_COMP, LANE_GEQ1, OPND_V, IDX1,
                      DST_I, IDX0, JMP_NEXT);
         5'd26: w = cw(ACC_FIRST, PRE_SHIFT, ROW_COMP, LANE_GEQ2, OPND_S, IDX2,
                      DST_NONE, IDX0, JMP_NEXT);
         5'd27: w = cw(ACC_ADD, PRE_MUL, ROW_COMP, LANE_GEQ2, OPND_V, IDX2,
                      DST_I, IDX1, JMP_NEXT);
         5'd28: w = nop_word();
         5'd29: w = cw(ACC_NOP, PRE_MUL, ROW_COMP, LANE_GEQ0, OPND_X, IDX0,
                      DST_I, IDX2, JMP_END);
         default: w = nop_word();
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: rtl/tssf_seq.sv
`default_nettype none

module tssf_seq (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire                    slot_free,
   output tssf_pkg::ctl_type       ctl,
   output tssf_pkg::seq_status_type stat
);
   import tssf_pkg::*;

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ctl_type         word;
   logic            emit;

   assign word = rom_word(pc_ff);
   assign ctl  = busy_ff ? word : nop_word();
   assign emit = busy_ff && (word.jmp == JMP_END) && slot_free;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = '0;
         end
      end else if (word.jmp == JMP_END) begin
         if (slot_free) begin
            busy_in = 1'b0;
            pc_in   = '0;
         end
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.emit = emit;
   assign stat.pc   = pc_ff;

endmodule

`default_nettype wire

// File: rtl/tssf_datapath.sv
`default_nettype none

module tssf_datapath #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_WIDTH   = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wen,
   input  wire  [tssf_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [tssf_pkg::REG_W-1:0]           csr_wdata,
   input  wire                                  start,
   input  wire                                  restart,
   input  wire  [SAMPLE_WIDTH-1:0]              sample_in,
   input  tssf_pkg::ctl_type                    ctl,
   output logic [SAMPLE_WIDTH-1:0]              y_out
);
   import tssf_pkg::*;

   localparam int PROD_W = COEF_WIDTH + STATE_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int RND_W  = ACC_W - FRAC_BITS;

   logic [REG_W-1:0]          cfg_ff [NUM_REGS];
   logic signed [STATE_W-1:0] x_ff;
   logic signed [STATE_W-1:0] v_ff [3];
   logic signed [STATE_W-1:0] i_ff [3];
   logic signed [STATE_W-1:0] s_ff [3];
   logic [SAMPLE_WIDTH-1:0]   y_ff;

   logic signed [COEF_WIDTH-1:0] coef;
   logic signed [STATE_W-1:0]    opnd;
   logic signed [PROD_W-1:0]     prod;
   logic signed [ACC_W-1:0]      pre_ff, pre_in;
   acc_op_type                   accop_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_rnd;
   logic [RND_W-1:0]             rnd;
   logic [STATE_W-1:0]           sat_state;
   logic [SAMPLE_WIDTH-1:0]      sat_out;
   logic                         ovf_state, ovf_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            cfg_ff[r] <= '0;
         end
      end else if (csr_wen && (csr_addr < CSR_ADDR_W'(NUM_REGS))) begin
         cfg_ff[csr_addr] <= csr_wdata;
      end
   end

   assign coef = cfg_ff[ctl.coef_row][int'(ctl.coef_lane) * COEF_WIDTH +: COEF_WIDTH];

   always_comb begin
      opnd = x_ff;
      for (int n = 0; n < 3; n++) begin
         if (ctl.opnd_idx == 2'(n)) begin
            case (ctl.opnd)
               OPND_V:  opnd = v_ff[n];
               OPND_I:  opnd = i_ff[n];
               OPND_S:  opnd = s_ff[n];
               default: opnd = x_ff;
            endcase
         end
      end
   end

   assign prod   = coef * opnd;
   assign pre_in = (ctl.pre_op == PRE_SHIFT)
                 ? ACC_W'(0) - (ACC_W'(opnd) <<< FRAC_BITS)
                 : ACC_W'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         accop_ff <= ACC_NOP;
      end else begin
         accop_ff <= ctl.acc_op;
      end
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
      case (accop_ff)
         ACC_FIRST: acc_ff <= pre_ff;
         ACC_ADD:   acc_ff <= acc_ff + pre_ff;
         default:   acc_ff <= acc_ff;
      endcase
   end

   // round half up, then clamp
   assign acc_rnd   = acc_ff + ACC_W'(1 << (FRAC_BITS - 1));
   assign rnd       = acc_rnd[ACC_W-1:FRAC_BITS];
   assign ovf_state = !((&rnd[RND_W-1:STATE_W-1]) || !(|rnd[RND_W-1:STATE_W-1]));
   assign ovf_out   = !((&rnd[RND_W-1:SAMPLE_WIDTH-1]) ||
                        !(|rnd[RND_W-1:SAMPLE_WIDTH-1]));
   assign sat_state = ovf_state ? {rnd[RND_W-1], {(STATE_W-1){!rnd[RND_W-1]}}}
                                : rnd[STATE_W-1:0];
   assign sat_out   = ovf_out ? {rnd[RND_W-1], {(SAMPLE_WIDTH-1){!rnd[RND_W-1]}}}
                              : rnd[SAMPLE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 3; n++) begin
            v_ff[n] <= '0;
            i_ff[n] <= '0;
         end
      end else if (start) begin
         if (restart) begin
            for (int n = 0; n < 3; n++) begin
               v_ff[n] <= '0;
               i_ff[n] <= '0;
            end
         end
      end else begin
         for (int n = 0; n < 3; n++) begin
            if (ctl.dest_idx == 2'(n)) begin
               if (ctl.dest == DST_V) begin
                  v_ff[n] <= sat_state;
               end
               if (ctl.dest == DST_I) begin
                  i_ff[n] <= sat_state;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= STATE_W'($signed(sample_in));
      end
      for (int n = 0; n < 3; n++) begin
         if ((ctl.dest == DST_S) && (ctl.dest_idx == 2'(n))) begin
            s_ff[n] <= sat_state;
         end
      end
      if (ctl.dest == DST_Y) begin
         y_ff <= sat_out;
      end
   end

   assign y_out = y_ff;

endmodule

`default_nettype wire

// File: rtl/tone_stack_state_space_filter_top.sv
// Three-capacitor tone stack filter, one audio sample per beat.
// req channel: tdata carries sample_in (signed), tuser carries restart, which
// clears the capacitor voltages and currents before that sample is filtered.
// rsp channel: tdata carries sample_out (signed, saturated), one beat per
// request beat, in order.
// csr port: write enable, register index and 64-bit data; index 0..3 are the
// treble, bass, mid and output coefficient rows, index 4 the companion terms.
// Write only while idle; other indexes are dropped.
// A small microprogram drives one shared multiply-accumulate unit with a
// registered product and accumulator: 30 control steps per sample. The
// response is registered on the last step, and a new request is taken only
// after the sequencer has finished the previous sample.
// The response sits in an output register; the next request is taken while
// it waits. When the receiver stalls, the sequencer holds on its last step
// until the previous response is taken.
// Reset clears the coefficients, the capacitor voltages and currents and both handshakes.
`default_nettype none

module tone_stack_state_space_filter_top #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_WIDTH   = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // sample_in
   input  wire  [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // restart
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // sample_out
   output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  wire                                  csr_wen,
   input  wire  [tssf_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [tssf_pkg::REG_W-1:0]           csr_wdata
);
   import tssf_pkg::*;

   localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   ctl_type                 ctl;
   seq_status_type          seq_stat;
   logic                    start;
   logic                    slot_free;
   logic [SAMPLE_WIDTH-1:0] y;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0]      rsp_data_ff;

   assign req_tready = !seq_stat.busy;
   assign start      = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   tssf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .slot_free (slot_free),
      .ctl       (ctl),
      .stat      (seq_stat)
   );

   tssf_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .start     (start),
      .restart   (req_tuser),
      .sample_in (req_tdata[SAMPLE_WIDTH-1:0]),
      .ctl       (ctl),
      .y_out     (y)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_stat.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_stat.emit) begin
         rsp_data_ff <= TDATA_W'(y);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "tone_stack_state_space_filter_top_assert.svh"

   `TSSF_CHECK_NEXT(a_start_runs, start, seq_stat.busy && (seq_stat.pc == '0))
   `TSSF_CHECK_NOW(a_emit_free, seq_stat.emit, seq_stat.busy && slot_free)
   `TSSF_CHECK_NEXT(a_emit_valid, seq_stat.emit, rsp_tvalid)

endmodule

`default_nettype wire
